// ----- rtl/tet_force_scatter_accumulate_top_assert.svh -----
// Assertion macros shared by the queue and back-end modules of the force scatter block.
`ifndef TET_FORCE_SCATTER_ACCUMULATE_TOP_ASSERT_SVH
`define TET_FORCE_SCATTER_ACCUMULATE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TFSA_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
`define TFSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define TFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define TFSA_ASSERT_NEVER(label, clk, rst_n, cond)
`define TFSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/tfsa_pkg.sv -----
package tfsa_pkg;

    localparam int TET_DEPTH = 1024;
    localparam int NODE_DEPTH = 1024;
    localparam int TET_AW = $clog2(TET_DEPTH);
    localparam int NODE_AW = $clog2(NODE_DEPTH);

    localparam int ID_W = 10;
    localparam int EXT_W = 17;
    localparam int CNT_W = 11;
    localparam int W_W = 18;
    localparam int F_W = 32;
    localparam int ACC_W = 48;
    localparam int PROD_W = 50;
    localparam int RND_W = 34;
    localparam int SUM_W = ACC_W + 1;
    localparam int FRAC_W = 16;
    localparam int ROUND_HALF = 32768;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_SCATTER = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_SKIPPED = 2'd1;
    localparam logic [1:0] STATUS_BAD_TET = 2'd2;
    localparam logic [1:0] STATUS_SATURATED = 2'd3;

    localparam logic [2:0] CMD_REPORT = 3'd0;
    localparam logic [2:0] CMD_LOAD = 3'd1;
    localparam logic [2:0] CMD_SCATTER = 3'd2;
    localparam logic [2:0] CMD_READ = 3'd3;
    localparam logic [2:0] CMD_WRITE = 3'd4;

    typedef struct packed {
        logic [2:0]                kind;
        logic [1:0]                status;
        logic [ID_W-1:0]           tet_index;
        logic [1:0]                corner;
        logic [ID_W-1:0]           node_index;
        logic [3:0][W_W-1:0]       weight;
        logic [F_W-1:0]            force_x;
        logic [F_W-1:0]            force_y;
        logic [F_W-1:0]            force_z;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

endpackage

// ----- rtl/tfsa_queue.sv -----
`include "tet_force_scatter_accumulate_top_assert.svh"

module tfsa_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  tfsa_pkg::cmd_chan_t in_chan,
    output logic                full,
    output tfsa_pkg::cmd_chan_t out_chan,
    input  logic                pop
);

    tfsa_pkg::cmd_t entry_reg [tfsa_pkg::QUEUE_DEPTH];
    logic [tfsa_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tfsa_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tfsa_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic empty;

    assign empty = (count_reg == '0);
    assign full = (count_reg == tfsa_pkg::QUEUE_CW'(tfsa_pkg::QUEUE_DEPTH));
    assign out_chan.valid = !empty;
    assign out_chan.cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (in_chan.valid)
        begin
            if (wr_ptr_reg == tfsa_pkg::QUEUE_AW'(tfsa_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == tfsa_pkg::QUEUE_AW'(tfsa_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (in_chan.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!in_chan.valid && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.valid)
            entry_reg[wr_ptr_reg] <= in_chan.cmd;
    end

    `TFSA_ASSERT_NEVER(a_push_when_full, clk, rst_n, in_chan.valid && full)
    `TFSA_ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && empty)
    `TFSA_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > tfsa_pkg::QUEUE_CW'(tfsa_pkg::QUEUE_DEPTH))

endmodule

// ----- rtl/tfsa_front.sv -----
module tfsa_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        full,
    input  logic [1:0]                  req_type,
    input  logic                        is_proxy,
    input  logic [tfsa_pkg::ID_W-1:0]   tet_index,
    input  logic [1:0]                  corner,
    input  logic [tfsa_pkg::ID_W-1:0]   node_index,
    input  logic signed [tfsa_pkg::W_W-1:0] weight_a,
    input  logic signed [tfsa_pkg::W_W-1:0] weight_b,
    input  logic signed [tfsa_pkg::W_W-1:0] weight_c,
    input  logic signed [tfsa_pkg::W_W-1:0] weight_d,
    input  logic signed [tfsa_pkg::F_W-1:0] force_x,
    input  logic signed [tfsa_pkg::F_W-1:0] force_y,
    input  logic signed [tfsa_pkg::F_W-1:0] force_z,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tfsa_pkg::CNT_W-1:0]  cfg_data,
    output tfsa_pkg::cmd_chan_t         push_chan
);

    logic [tfsa_pkg::CNT_W-1:0] tet_count_reg;
    logic [tfsa_pkg::EXT_W-1:0] tet_ext;
    logic tet_in_table;

    assign cfg_ready = 1'b1;
    assign tet_ext = tfsa_pkg::EXT_W'(tet_index);
    assign tet_in_table = (tet_ext < tfsa_pkg::EXT_W'(tfsa_pkg::TET_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tet_count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            tet_count_reg <= cfg_data;
    end

    // Each item is sorted here so that the back end only has to carry it out.
    always_comb
    begin
        push_chan.valid = start && !full;
        push_chan.cmd.kind = tfsa_pkg::CMD_REPORT;
        push_chan.cmd.status = tfsa_pkg::STATUS_DONE;
        push_chan.cmd.tet_index = tet_index;
        push_chan.cmd.corner = corner;
        push_chan.cmd.node_index = node_index;
        push_chan.cmd.weight[0] = weight_a;
        push_chan.cmd.weight[1] = weight_b;
        push_chan.cmd.weight[2] = weight_c;
        push_chan.cmd.weight[3] = weight_d;
        push_chan.cmd.force_x = force_x;
        push_chan.cmd.force_y = force_y;
        push_chan.cmd.force_z = force_z;
        case (req_type)
            tfsa_pkg::REQ_LOAD:
            begin
                if (tet_in_table)
                    push_chan.cmd.kind = tfsa_pkg::CMD_LOAD;
                else
                    push_chan.cmd.status = tfsa_pkg::STATUS_BAD_TET;
            end
            tfsa_pkg::REQ_SCATTER:
            begin
                if (!is_proxy)
                    push_chan.cmd.status = tfsa_pkg::STATUS_SKIPPED;
                else if (!tet_in_table ||
                         tet_ext >= tfsa_pkg::EXT_W'(tet_count_reg))
                    push_chan.cmd.status = tfsa_pkg::STATUS_BAD_TET;
                else
                    push_chan.cmd.kind = tfsa_pkg::CMD_SCATTER;
            end
            tfsa_pkg::REQ_READ:
                push_chan.cmd.kind = tfsa_pkg::CMD_READ;
            default:
                push_chan.cmd.kind = tfsa_pkg::CMD_WRITE;
        endcase
    end

endmodule

// ----- rtl/tfsa_back.sv -----
`include "tet_force_scatter_accumulate_top_assert.svh"

module tfsa_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tfsa_pkg::cmd_chan_t              head_chan,
    output logic                             pop,
    output logic                             done,
    output logic [1:0]                       status,
    output logic signed [tfsa_pkg::ACC_W-1:0] node_force_x_out,
    output logic signed [tfsa_pkg::ACC_W-1:0] node_force_y_out,
    output logic signed [tfsa_pkg::ACC_W-1:0] node_force_z_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TRD = 3'd1;
    localparam logic [2:0] ST_CRD = 3'd2;
    localparam logic [2:0] ST_CRND = 3'd3;
    localparam logic [2:0] ST_CWR = 3'd4;
    localparam logic [2:0] ST_NRD = 3'd5;

    function automatic logic [tfsa_pkg::ACC_W:0] sat_fit(
        input logic signed [tfsa_pkg::SUM_W-1:0] s);
        logic [tfsa_pkg::ACC_W:0] r;
        if (s[tfsa_pkg::SUM_W-1] != s[tfsa_pkg::SUM_W-2])
            r = {1'b1, s[tfsa_pkg::SUM_W-1], {(tfsa_pkg::ACC_W-1){~s[tfsa_pkg::SUM_W-1]}}};
        else
            r = {1'b0, s[tfsa_pkg::ACC_W-1:0]};
        return r;
    endfunction

    logic [3:0][tfsa_pkg::ID_W-1:0] tet_mem [tfsa_pkg::TET_DEPTH];
    logic [tfsa_pkg::ACC_W-1:0] acc_x_mem [tfsa_pkg::NODE_DEPTH];
    logic [tfsa_pkg::ACC_W-1:0] acc_y_mem [tfsa_pkg::NODE_DEPTH];
    logic [tfsa_pkg::ACC_W-1:0] acc_z_mem [tfsa_pkg::NODE_DEPTH];

    logic [3:0][tfsa_pkg::ID_W-1:0] tet_rd_reg;
    logic signed [tfsa_pkg::ACC_W-1:0] acc_x_rd_reg, acc_y_rd_reg, acc_z_rd_reg;

    logic [2:0] state_reg, state_next;
    tfsa_pkg::cmd_t cmd_reg, cmd_next;
    logic [1:0] corner_reg, corner_next;
    logic sat_reg, sat_next;
    logic [tfsa_pkg::NODE_AW-1:0] node_addr_reg, node_addr_next;
    logic signed [tfsa_pkg::PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [tfsa_pkg::PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [tfsa_pkg::RND_W-1:0] rnd_x_reg, rnd_y_reg, rnd_z_reg;
    logic signed [tfsa_pkg::RND_W-1:0] rnd_x_next, rnd_y_next, rnd_z_next;
    logic done_reg, done_next;
    logic [1:0] status_reg, status_next;
    logic signed [tfsa_pkg::ACC_W-1:0] force_x_reg, force_y_reg, force_z_reg;
    logic signed [tfsa_pkg::ACC_W-1:0] force_x_next, force_y_next, force_z_next;

    logic tet_we, tet_re;
    logic [tfsa_pkg::TET_AW-1:0] tet_addr;
    logic acc_we, acc_re;
    logic [tfsa_pkg::NODE_AW-1:0] acc_waddr, acc_raddr;
    logic [tfsa_pkg::ACC_W-1:0] acc_x_wdata, acc_y_wdata, acc_z_wdata;

    logic [tfsa_pkg::EXT_W-1:0] head_tet_ext, head_node_ext, cmd_node_ext, corner_node_ext;
    logic head_node_ok, cmd_node_ok, corner_node_ok;
    logic signed [tfsa_pkg::W_W-1:0] w_sel;
    logic [tfsa_pkg::ACC_W:0] fit_x, fit_y, fit_z;
    logic sat_any, sat_now, last_corner;

    assign head_tet_ext = tfsa_pkg::EXT_W'(head_chan.cmd.tet_index);
    assign head_node_ext = tfsa_pkg::EXT_W'(head_chan.cmd.node_index);
    assign cmd_node_ext = tfsa_pkg::EXT_W'(cmd_reg.node_index);
    assign corner_node_ext = tfsa_pkg::EXT_W'(tet_rd_reg[corner_reg]);
    assign head_node_ok = (head_node_ext < tfsa_pkg::EXT_W'(tfsa_pkg::NODE_DEPTH));
    assign cmd_node_ok = (cmd_node_ext < tfsa_pkg::EXT_W'(tfsa_pkg::NODE_DEPTH));
    assign corner_node_ok = (corner_node_ext < tfsa_pkg::EXT_W'(tfsa_pkg::NODE_DEPTH));
    assign tet_addr = head_tet_ext[tfsa_pkg::TET_AW-1:0];
    assign w_sel = $signed(cmd_reg.weight[corner_reg]);
    assign last_corner = (corner_reg == 2'd3);

    assign fit_x = sat_fit(tfsa_pkg::SUM_W'(acc_x_rd_reg) + tfsa_pkg::SUM_W'(rnd_x_reg));
    assign fit_y = sat_fit(tfsa_pkg::SUM_W'(acc_y_rd_reg) + tfsa_pkg::SUM_W'(rnd_y_reg));
    assign fit_z = sat_fit(tfsa_pkg::SUM_W'(acc_z_rd_reg) + tfsa_pkg::SUM_W'(rnd_z_reg));
    assign sat_any = fit_x[tfsa_pkg::ACC_W] || fit_y[tfsa_pkg::ACC_W] || fit_z[tfsa_pkg::ACC_W];

    assign prod_x_next = $signed(w_sel) * $signed(cmd_reg.force_x);
    assign prod_y_next = $signed(w_sel) * $signed(cmd_reg.force_y);
    assign prod_z_next = $signed(w_sel) * $signed(cmd_reg.force_z);
    assign rnd_x_next = tfsa_pkg::RND_W'((prod_x_reg +
        tfsa_pkg::PROD_W'(tfsa_pkg::ROUND_HALF)) >>> tfsa_pkg::FRAC_W);
    assign rnd_y_next = tfsa_pkg::RND_W'((prod_y_reg +
        tfsa_pkg::PROD_W'(tfsa_pkg::ROUND_HALF)) >>> tfsa_pkg::FRAC_W);
    assign rnd_z_next = tfsa_pkg::RND_W'((prod_z_reg +
        tfsa_pkg::PROD_W'(tfsa_pkg::ROUND_HALF)) >>> tfsa_pkg::FRAC_W);

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        corner_next = corner_reg;
        sat_next = sat_reg;
        node_addr_next = node_addr_reg;
        done_next = 1'b0;
        status_next = tfsa_pkg::STATUS_DONE;
        force_x_next = '0;
        force_y_next = '0;
        force_z_next = '0;
        pop = 1'b0;
        tet_we = 1'b0;
        tet_re = 1'b0;
        acc_we = 1'b0;
        acc_re = 1'b0;
        acc_waddr = head_node_ext[tfsa_pkg::NODE_AW-1:0];
        acc_raddr = head_node_ext[tfsa_pkg::NODE_AW-1:0];
        acc_x_wdata = tfsa_pkg::ACC_W'($signed(head_chan.cmd.force_x));
        acc_y_wdata = tfsa_pkg::ACC_W'($signed(head_chan.cmd.force_y));
        acc_z_wdata = tfsa_pkg::ACC_W'($signed(head_chan.cmd.force_z));
        sat_now = sat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_chan.valid)
                begin
                    pop = 1'b1;
                    cmd_next = head_chan.cmd;
                    case (head_chan.cmd.kind)
                        tfsa_pkg::CMD_LOAD:
                        begin
                            tet_we = 1'b1;
                            done_next = 1'b1;
                        end
                        tfsa_pkg::CMD_WRITE:
                        begin
                            acc_we = head_node_ok;
                            done_next = 1'b1;
                        end
                        tfsa_pkg::CMD_READ:
                        begin
                            acc_re = head_node_ok;
                            state_next = ST_NRD;
                        end
                        tfsa_pkg::CMD_SCATTER:
                        begin
                            tet_re = 1'b1;
                            sat_next = 1'b0;
                            corner_next = 2'd0;
                            state_next = ST_TRD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            status_next = head_chan.cmd.status;
                        end
                    endcase
                end
            end
            ST_NRD:
            begin
                done_next = 1'b1;
                if (cmd_node_ok)
                begin
                    force_x_next = acc_x_rd_reg;
                    force_y_next = acc_y_rd_reg;
                    force_z_next = acc_z_rd_reg;
                end
                state_next = ST_IDLE;
            end
            ST_TRD:
                state_next = ST_CRD;
            ST_CRD:
            begin
                if (corner_node_ok)
                begin
                    acc_re = 1'b1;
                    acc_raddr = corner_node_ext[tfsa_pkg::NODE_AW-1:0];
                    node_addr_next = corner_node_ext[tfsa_pkg::NODE_AW-1:0];
                    state_next = ST_CRND;
                end
                else if (last_corner)
                begin
                    done_next = 1'b1;
                    status_next = sat_reg ? tfsa_pkg::STATUS_SATURATED : tfsa_pkg::STATUS_DONE;
                    state_next = ST_IDLE;
                end
                else
                    corner_next = corner_reg + 2'd1;
            end
            ST_CRND:
                state_next = ST_CWR;
            ST_CWR:
            begin
                acc_we = 1'b1;
                acc_waddr = node_addr_reg;
                acc_x_wdata = fit_x[tfsa_pkg::ACC_W-1:0];
                acc_y_wdata = fit_y[tfsa_pkg::ACC_W-1:0];
                acc_z_wdata = fit_z[tfsa_pkg::ACC_W-1:0];
                sat_now = sat_reg || sat_any;
                sat_next = sat_now;
                if (last_corner)
                begin
                    done_next = 1'b1;
                    status_next = sat_now ? tfsa_pkg::STATUS_SATURATED : tfsa_pkg::STATUS_DONE;
                    state_next = ST_IDLE;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next = ST_CRD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            corner_reg <= 2'd0;
            sat_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            corner_reg <= corner_next;
            sat_reg <= sat_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        node_addr_reg <= node_addr_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        prod_z_reg <= prod_z_next;
        rnd_x_reg <= rnd_x_next;
        rnd_y_reg <= rnd_y_next;
        rnd_z_reg <= rnd_z_next;
        status_reg <= status_next;
        force_x_reg <= force_x_next;
        force_y_reg <= force_y_next;
        force_z_reg <= force_z_next;
    end

    always_ff @(posedge clk)
    begin
        if (tet_we)
            tet_mem[tet_addr][head_chan.cmd.corner] <= head_chan.cmd.node_index;
        if (tet_re)
            tet_rd_reg <= tet_mem[tet_addr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_x_mem[acc_waddr] <= acc_x_wdata;
            acc_y_mem[acc_waddr] <= acc_y_wdata;
            acc_z_mem[acc_waddr] <= acc_z_wdata;
        end
        if (acc_re)
        begin
            acc_x_rd_reg <= acc_x_mem[acc_raddr];
            acc_y_rd_reg <= acc_y_mem[acc_raddr];
            acc_z_rd_reg <= acc_z_mem[acc_raddr];
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign node_force_x_out = force_x_reg;
    assign node_force_y_out = force_y_reg;
    assign node_force_z_out = force_z_reg;

    `TFSA_ASSERT_IMPLIES(a_forces_zero_off_status, clk, rst_n, done_reg && status_reg != tfsa_pkg::STATUS_DONE, force_x_reg == '0 && force_y_reg == '0 && force_z_reg == '0)
    `TFSA_ASSERT_NEXT(a_sat_sticky, clk, rst_n, state_reg == ST_CWR && sat_any, sat_reg)

endmodule

// ----- rtl/tet_force_scatter_accumulate_top.sv -----
// A done strobe is registered. Loads, writes and rejected scatters are answered from the idle
// state, reads after the node read state, and scatters after the read, round and write states
// of each in-range corner node. Throughput: the back end serialises one item at a time; a
// scatter holds it through the read, round and write steps of each accumulator update.
// A two-entry queue lets start be taken while the back end works. Results cannot be stalled.
// Reset clears control state only; table and accumulator memories are undefined until written.
module tet_force_scatter_accumulate_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       req_type,
    input  logic                             is_proxy,
    input  logic [tfsa_pkg::ID_W-1:0]        tet_index,
    input  logic [1:0]                       corner,
    input  logic [tfsa_pkg::ID_W-1:0]        node_index,
    input  logic signed [tfsa_pkg::W_W-1:0]  weight_a,
    input  logic signed [tfsa_pkg::W_W-1:0]  weight_b,
    input  logic signed [tfsa_pkg::W_W-1:0]  weight_c,
    input  logic signed [tfsa_pkg::W_W-1:0]  weight_d,
    input  logic signed [tfsa_pkg::F_W-1:0]  force_x,
    input  logic signed [tfsa_pkg::F_W-1:0]  force_y,
    input  logic signed [tfsa_pkg::F_W-1:0]  force_z,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tfsa_pkg::CNT_W-1:0]       cfg_data,
    output logic                             done,
    output logic [1:0]                       status,
    output logic signed [tfsa_pkg::ACC_W-1:0] node_force_x_out,
    output logic signed [tfsa_pkg::ACC_W-1:0] node_force_y_out,
    output logic signed [tfsa_pkg::ACC_W-1:0] node_force_z_out
);

    tfsa_pkg::cmd_chan_t push_chan;
    tfsa_pkg::cmd_chan_t head_chan;
    logic q_full;
    logic q_pop;

    assign busy = q_full;

    tfsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .full       (q_full),
        .req_type   (req_type),
        .is_proxy   (is_proxy),
        .tet_index  (tet_index),
        .corner     (corner),
        .node_index (node_index),
        .weight_a   (weight_a),
        .weight_b   (weight_b),
        .weight_c   (weight_c),
        .weight_d   (weight_d),
        .force_x    (force_x),
        .force_y    (force_y),
        .force_z    (force_z),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_chan  (push_chan)
    );

    tfsa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (push_chan),
        .full     (q_full),
        .out_chan (head_chan),
        .pop      (q_pop)
    );

    tfsa_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_chan        (head_chan),
        .pop              (q_pop),
        .done             (done),
        .status           (status),
        .node_force_x_out (node_force_x_out),
        .node_force_y_out (node_force_y_out),
        .node_force_z_out (node_force_z_out)
    );

endmodule
